@@ rtl/stt_pkg.sv @@
// Token codes, scanner modes, token record type and character classes for the source tokenizer.
package stt_pkg;

    localparam int unsigned MaxTok = 3;

    localparam logic [5:0] K_NEWLINE    = 6'd0;
    localparam logic [5:0] K_LPAREN     = 6'd1;
    localparam logic [5:0] K_RPAREN     = 6'd2;
    localparam logic [5:0] K_LBRACK     = 6'd3;
    localparam logic [5:0] K_RBRACK     = 6'd4;
    localparam logic [5:0] K_LCURLY     = 6'd5;
    localparam logic [5:0] K_RCURLY     = 6'd6;
    localparam logic [5:0] K_COMMA      = 6'd7;
    localparam logic [5:0] K_STOP       = 6'd8;
    localparam logic [5:0] K_COLON      = 6'd9;
    localparam logic [5:0] K_SEMI       = 6'd10;
    localparam logic [5:0] K_AMP        = 6'd11;
    localparam logic [5:0] K_AT         = 6'd12;
    localparam logic [5:0] K_DQUOTE     = 6'd13;
    localparam logic [5:0] K_SQUOTE     = 6'd14;
    localparam logic [5:0] K_EQUALS     = 6'd15;
    localparam logic [5:0] K_EQ         = 6'd16;
    localparam logic [5:0] K_LT         = 6'd17;
    localparam logic [5:0] K_LEQ        = 6'd18;
    localparam logic [5:0] K_SHL        = 6'd19;
    localparam logic [5:0] K_SWAP       = 6'd20;
    localparam logic [5:0] K_GT         = 6'd21;
    localparam logic [5:0] K_GEQ        = 6'd22;
    localparam logic [5:0] K_SHR        = 6'd23;
    localparam logic [5:0] K_SLASH      = 6'd24;
    localparam logic [5:0] K_DIV_ASSIGN = 6'd25;
    localparam logic [5:0] K_BSLASH     = 6'd26;
    localparam logic [5:0] K_PLUS       = 6'd27;
    localparam logic [5:0] K_ADD_ASSIGN = 6'd28;
    localparam logic [5:0] K_INC        = 6'd29;
    localparam logic [5:0] K_MINUS      = 6'd30;
    localparam logic [5:0] K_SUB_ASSIGN = 6'd31;
    localparam logic [5:0] K_ARROW      = 6'd32;
    localparam logic [5:0] K_DEC        = 6'd33;
    localparam logic [5:0] K_STAR       = 6'd34;
    localparam logic [5:0] K_MUL_ASSIGN = 6'd35;
    localparam logic [5:0] K_NAME       = 6'd36;
    localparam logic [5:0] K_FN         = 6'd37;
    localparam logic [5:0] K_STRUCT     = 6'd38;
    localparam logic [5:0] K_USE        = 6'd39;
    localparam logic [5:0] K_WHILE      = 6'd40;
    localparam logic [5:0] K_FOR        = 6'd41;
    localparam logic [5:0] K_IF         = 6'd42;
    localparam logic [5:0] K_ELIF       = 6'd43;
    localparam logic [5:0] K_ELSE       = 6'd44;
    localparam logic [5:0] K_IN         = 6'd45;
    localparam logic [5:0] K_BIN        = 6'd46;
    localparam logic [5:0] K_HEX        = 6'd47;
    localparam logic [5:0] K_DECIMAL    = 6'd48;
    localparam logic [5:0] K_ERROR      = 6'd50;

    localparam logic [23:0] LineMax = 24'hFFFFFF;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_LT_MINUS, M_BLOCK, M_BLOCK_STAR, M_LINE,
        M_WORD, M_ZERO, M_BIN, M_HEX, M_DEC
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start_pos;
        logic [23:0] end_pos;
        logic [23:0] line_num;
        logic        last;
    } t_tok;

    // what a byte does when it opens a new token
    typedef struct packed {
        logic       emit;
        logic [5:0] kind;
        t_mode      mode;
        logic       set_start;
        logic       is_op;
        logic       is_word;
        logic       err;
        logic       bump;
    } t_start;

    function automatic logic f_letter(input logic [7:0] c);
        return (c > 8'd96 && c < 8'd123) || (c > 8'd64 && c < 8'd91);
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return c > 8'd47 && c < 8'd58;
    endfunction

    function automatic logic f_hex(input logic [7:0] c);
        return f_digit(c) || (c > 8'd64 && c < 8'd71) || (c > 8'd96 && c < 8'd103);
    endfunction

    function automatic logic [5:0] f_single(input logic [7:0] op);
        logic [5:0] k;
        case (op)
            "=":     k = K_EQUALS;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "/":     k = K_SLASH;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // whole-word keyword match on the packed first six bytes
    function automatic logic [5:0] f_word_kind(input logic [47:0] p, input logic [2:0] n);
        logic [5:0] k;
        k = K_NAME;
        if      (n == 3'd2 && p == 48'h666E)         k = K_FN;
        else if (n == 3'd6 && p == 48'h737472756374) k = K_STRUCT;
        else if (n == 3'd3 && p == 48'h757365)       k = K_USE;
        else if (n == 3'd5 && p == 48'h7768696C65)   k = K_WHILE;
        else if (n == 3'd3 && p == 48'h666F72)       k = K_FOR;
        else if (n == 3'd2 && p == 48'h6966)         k = K_IF;
        else if (n == 3'd4 && p == 48'h656C6966)     k = K_ELIF;
        else if (n == 3'd4 && p == 48'h656C7365)     k = K_ELSE;
        else if (n == 3'd2 && p == 48'h696E)         k = K_IN;
        return k;
    endfunction

    function automatic t_start f_start(input logic [7:0] c);
        t_start s;
        s = '0;
        s.mode = M_IDLE;
        s.emit = 1'b1;
        case (c)
            " ":     s.emit = 1'b0;
            8'h0A:   begin s.kind = K_NEWLINE; s.bump = 1'b1; end
            "(":     s.kind = K_LPAREN;
            ")":     s.kind = K_RPAREN;
            "[":     s.kind = K_LBRACK;
            "]":     s.kind = K_RBRACK;
            "{":     s.kind = K_LCURLY;
            "}":     s.kind = K_RCURLY;
            ",":     s.kind = K_COMMA;
            ".":     s.kind = K_STOP;
            ":":     s.kind = K_COLON;
            ";":     s.kind = K_SEMI;
            "&":     s.kind = K_AMP;
            "@":     s.kind = K_AT;
            8'h22:   s.kind = K_DQUOTE;
            8'h27:   s.kind = K_SQUOTE;
            8'h5C:   s.kind = K_BSLASH;
            "=", "<", ">", "/", "+", "-", "*": begin
                s.emit = 1'b0; s.mode = M_OP; s.set_start = 1'b1; s.is_op = 1'b1;
            end
            default: begin
                s.set_start = 1'b1;
                s.emit = 1'b0;
                if (f_letter(c) || c == "_") begin
                    s.mode = M_WORD; s.is_word = 1'b1;
                end else if (c == "0") begin
                    s.mode = M_ZERO;
                end else if (f_digit(c)) begin
                    s.mode = M_DEC;
                end else begin
                    s.emit = 1'b1; s.kind = K_ERROR; s.err = 1'b1;
                end
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/source_text_tokenizer_top.sv @@
// Streaming source tokenizer: one byte per beat, up to three tokens per byte into a result queue.
// A byte's tokens are registered into the queue and are offered behind the tokens queued before.
// Throughput: one unstalled byte per cycle; the scanner is one pass of logic from its registers.
// Input stalls only while the 8-entry token queue has fewer than three free slots.
// Reset (synchronous, active low) empties the queue and puts the scanner in its start state;
// a byte marked final_byte also returns the scanner to the start state after flushing.
module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int unsigned POS_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_token_kind,
    output logic [23:0] o_start_pos,
    output logic [23:0] o_end_pos,
    output logic [23:0] o_line_num,
    output logic        o_last_of_run
);

    localparam logic [POS_WIDTH-1:0] PosOne = POS_WIDTH'(1);

    t_mode                r_mode,   n_mode;
    logic [POS_WIDTH-1:0] r_pos;
    logic [POS_WIDTH-1:0] r_tstart, n_tstart;
    logic [23:0]          r_line,   n_line;
    logic [7:0]           r_look,   n_look;
    logic [47:0]          r_prefix, n_prefix;
    logic [2:0]           r_wlen,   n_wlen;
    logic                 r_err,    n_err;

    t_tok       slot [MaxTok];
    logic [1:0] n_cnt;

    t_tok       r_fifo [8];
    logic [2:0] r_wr, r_rd;
    logic [3:0] r_cnt;

    logic in_fire, out_fire;
    assign o_in_stall  = r_cnt > 4'd5;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_cnt != 4'd0;
    assign out_fire    = o_out_valid && !i_out_stall;

    function automatic t_tok f_tok(input logic [5:0] k, input logic [POS_WIDTH-1:0] s,
                                   input logic [POS_WIDTH-1:0] e, input logic [23:0] l);
        t_tok t;
        t.kind      = k;
        t.start_pos = 24'(s);
        t.end_pos   = 24'(e);
        t.line_num  = l;
        t.last      = 1'b0;
        return t;
    endfunction

    always_comb begin
        t_start               st;
        logic                 do_start;
        logic [7:0]           op;
        logic [POS_WIDTH-1:0] ts;
        logic [5:0]           k2;
        logic                 op_hold;
        logic [POS_WIDTH-1:0] pos1;
        n_mode   = r_mode;
        n_tstart = r_tstart;
        n_line   = r_line;
        n_look   = r_look;
        n_prefix = r_prefix;
        n_wlen   = r_wlen;
        n_err    = r_err;
        n_cnt    = 2'd0;
        for (int k = 0; k < MaxTok; k++) slot[k] = '0;
        st       = f_start(i_ch);
        do_start = 1'b0;
        pos1     = r_pos + PosOne;
        op       = (r_mode == M_LT_MINUS) ? 8'("-") : r_look;
        ts       = (r_mode == M_LT_MINUS) ? r_tstart + PosOne : r_tstart;
        k2       = K_ERROR;
        op_hold  = 1'b0;

        if (!r_err) begin
            case (r_mode)
                M_OP, M_LT_MINUS: begin
                    if (r_mode == M_LT_MINUS && i_ch == ">") begin
                        slot[0] = f_tok(K_SWAP, r_tstart, pos1, r_line);
                        n_cnt   = 2'd1;
                        n_mode  = M_IDLE;
                    end else begin
                        if (r_mode == M_LT_MINUS) begin
                            // the '<' goes out alone, the '-' is scanned again
                            slot[0]  = f_tok(K_LT, r_tstart, ts, r_line);
                            n_cnt    = 2'd1;
                            n_tstart = ts;
                            n_look   = "-";
                        end
                        op_hold = 1'b1;
                        case (op)
                            "=": if (i_ch == "=") k2 = K_EQ;
                            "<": begin
                                if (i_ch == "<") k2 = K_SHL;
                                else if (i_ch == "=") k2 = K_LEQ;
                                else if (i_ch == "-") begin n_mode = M_LT_MINUS; op_hold = 1'b0; end
                            end
                            ">": begin
                                if (i_ch == ">") k2 = K_SHR;
                                else if (i_ch == "=") k2 = K_GEQ;
                            end
                            "/": begin
                                if (i_ch == "*") begin n_mode = M_BLOCK; op_hold = 1'b0; end
                                else if (i_ch == "/") begin n_mode = M_LINE; op_hold = 1'b0; end
                                else if (i_ch == "=") k2 = K_DIV_ASSIGN;
                            end
                            "+": begin
                                if (i_ch == "=") k2 = K_ADD_ASSIGN;
                                else if (i_ch == "+") k2 = K_INC;
                            end
                            "-": begin
                                if (i_ch == "=") k2 = K_SUB_ASSIGN;
                                else if (i_ch == ">") k2 = K_ARROW;
                                else if (i_ch == "-") k2 = K_DEC;
                            end
                            "*": if (i_ch == "=") k2 = K_MUL_ASSIGN;
                            default: k2 = K_ERROR;
                        endcase
                        if (op_hold) begin
                            n_mode = M_IDLE;
                            if (k2 != K_ERROR) begin
                                slot[n_cnt] = f_tok(k2, ts, pos1, r_line);
                                n_cnt       = n_cnt + 2'd1;
                            end else begin
                                slot[n_cnt] = f_tok(f_single(op), ts, ts + PosOne, r_line);
                                n_cnt       = n_cnt + 2'd1;
                                do_start    = 1'b1;
                            end
                        end
                    end
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    if (i_ch == "/" && r_mode == M_BLOCK_STAR) n_mode = M_IDLE;
                    else if (i_ch == "*") n_mode = M_BLOCK_STAR;
                    else begin
                        if (i_ch == 8'h0A && r_line != LineMax) n_line = r_line + 24'd1;
                        n_mode = M_BLOCK;
                    end
                end
                M_LINE: if (i_ch == 8'h0A) do_start = 1'b1;
                M_WORD: begin
                    if (f_letter(i_ch) || i_ch == "_" || f_digit(i_ch)) begin
                        if (r_wlen < 3'd6) n_prefix = {r_prefix[39:0], i_ch};
                        if (r_wlen < 3'd7) n_wlen = r_wlen + 3'd1;
                    end else begin
                        slot[0]  = f_tok(f_word_kind(r_prefix, r_wlen), r_tstart, r_pos, r_line);
                        n_cnt    = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (i_ch == "b") n_mode = M_BIN;
                    else if (i_ch == "x" || i_ch == "X") n_mode = M_HEX;
                    else if (f_digit(i_ch) || i_ch == "_") n_mode = M_DEC;
                    else begin
                        slot[0]  = f_tok(K_DECIMAL, r_tstart, r_pos, r_line);
                        n_cnt    = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_BIN: if (!(i_ch == "0" || i_ch == "1" || i_ch == "_")) begin
                    slot[0]  = f_tok(K_BIN, r_tstart, r_pos, r_line);
                    n_cnt    = 2'd1;
                    do_start = 1'b1;
                end
                M_HEX: if (!(f_hex(i_ch) || i_ch == "_")) begin
                    slot[0]  = f_tok(K_HEX, r_tstart, r_pos, r_line);
                    n_cnt    = 2'd1;
                    do_start = 1'b1;
                end
                M_DEC: if (!(f_digit(i_ch) || i_ch == "_")) begin
                    slot[0]  = f_tok(K_DECIMAL, r_tstart, r_pos, r_line);
                    n_cnt    = 2'd1;
                    do_start = 1'b1;
                end
                default: do_start = 1'b1;
            endcase

            if (do_start) begin
                n_mode = st.mode;
                if (st.set_start) n_tstart = r_pos;
                if (st.is_op) n_look = i_ch;
                if (st.is_word) begin
                    n_prefix = {40'd0, i_ch};
                    n_wlen   = 3'd1;
                end
                if (st.err) n_err = 1'b1;
                if (st.bump && r_line != LineMax) n_line = r_line + 24'd1;
                if (st.emit && n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(st.kind, r_pos, pos1, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
            end
        end

        // end of source: flush whatever token is still open
        if (i_final_byte && !n_err) begin
            case (n_mode)
                M_OP: if (n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(f_single(n_look), n_tstart, n_tstart + PosOne, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
                M_LT_MINUS: begin
                    if (n_cnt < 2'd3) begin
                        slot[n_cnt] = f_tok(K_LT, n_tstart, n_tstart + PosOne, n_line);
                        n_cnt       = n_cnt + 2'd1;
                    end
                    if (n_cnt < 2'd3) begin
                        slot[n_cnt] = f_tok(K_MINUS, n_tstart + PosOne,
                                            n_tstart + POS_WIDTH'(2), n_line);
                        n_cnt       = n_cnt + 2'd1;
                    end
                end
                M_WORD: if (n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(f_word_kind(n_prefix, n_wlen), n_tstart, pos1, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
                M_ZERO, M_DEC: if (n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(K_DECIMAL, n_tstart, pos1, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
                M_BIN: if (n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(K_BIN, n_tstart, pos1, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
                M_HEX: if (n_cnt < 2'd3) begin
                    slot[n_cnt] = f_tok(K_HEX, n_tstart, pos1, n_line);
                    n_cnt       = n_cnt + 2'd1;
                end
                default: ;
            endcase
        end

        if (n_cnt != 2'd0) slot[n_cnt - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_line   <= 24'd1;
            r_look   <= '0;
            r_prefix <= '0;
            r_wlen   <= '0;
            r_err    <= 1'b0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
        end else begin
            if (in_fire) begin
                if (i_final_byte) begin
                    r_mode   <= M_IDLE;
                    r_pos    <= '0;
                    r_tstart <= '0;
                    r_line   <= 24'd1;
                    r_look   <= '0;
                    r_prefix <= '0;
                    r_wlen   <= '0;
                    r_err    <= 1'b0;
                end else begin
                    r_mode   <= n_mode;
                    r_pos    <= r_pos + PosOne;
                    r_tstart <= n_tstart;
                    r_line   <= n_line;
                    r_look   <= n_look;
                    r_prefix <= n_prefix;
                    r_wlen   <= n_wlen;
                    r_err    <= n_err;
                end
                r_wr <= r_wr + 3'(n_cnt);
            end
            if (out_fire) r_rd <= r_rd + 3'd1;
            r_cnt <= r_cnt + ((in_fire) ? 4'(n_cnt) : 4'd0) - (out_fire ? 4'd1 : 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < MaxTok; k++) begin
                if (2'(k) < n_cnt) r_fifo[r_wr + 3'(k)] <= slot[k];
            end
        end
    end

    assign o_token_kind  = r_fifo[r_rd].kind;
    assign o_start_pos   = r_fifo[r_rd].start_pos;
    assign o_end_pos     = r_fifo[r_rd].end_pos;
    assign o_line_num    = r_fifo[r_rd].line_num;
    assign o_last_of_run = r_fifo[r_rd].last;

endmodule

@@ verif/source_text_tokenizer_top_test.sv @@
// Self-checking testbench for the streaming source tokenizer.
`timescale 1ns / 1ps

module source_text_tokenizer_top_test;
    import stt_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start_pos;
        logic [23:0] end_pos;
        logic [23:0] line_num;
        logic        last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_ch = '0;
    logic        i_final_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [5:0]  o_token_kind;
    logic [23:0] o_start_pos;
    logic [23:0] o_end_pos;
    logic [23:0] o_line_num;
    logic        o_last_of_run;

    source_text_tokenizer_top dut (.*);

    always #4 i_clk = ~i_clk;

    // scanner copy
    t_mode       sc_mode;
    logic [23:0] sc_pos, sc_line, sc_start;
    logic [7:0]  sc_op;
    logic [47:0] sc_prefix;
    logic [2:0]  sc_len;
    logic        sc_err;

    t_token tokens_due[$];
    t_token step_toks[$];
    int     n_errors = 0;
    int     n_bytes = 0;
    int     n_tokens = 0;
    longint cycle_count = 0;
    logic   idle_on = 1'b1;

    function automatic logic is_let(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_hx(logic [7:0] c);
        return is_dig(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] op);
        case (op)
            "=": return K_EQUALS;
            "<": return K_LT;
            ">": return K_GT;
            "/": return K_SLASH;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] keyword_kind();
        case (sc_len)
            3'd2: if (sc_prefix == {32'h0, "fn"}) return K_FN;
                  else if (sc_prefix == {32'h0, "if"}) return K_IF;
                  else if (sc_prefix == {32'h0, "in"}) return K_IN;
            3'd3: if (sc_prefix == {24'h0, "use"}) return K_USE;
                  else if (sc_prefix == {24'h0, "for"}) return K_FOR;
            3'd4: if (sc_prefix == {16'h0, "elif"}) return K_ELIF;
                  else if (sc_prefix == {16'h0, "else"}) return K_ELSE;
            3'd5: if (sc_prefix == {8'h0, "while"}) return K_WHILE;
            3'd6: if (sc_prefix == "struct") return K_STRUCT;
            default: ;
        endcase
        return K_NAME;
    endfunction

    task automatic put_tok(logic [5:0] k, logic [23:0] s, logic [23:0] e);
        if (step_toks.size() < MaxTok) step_toks.push_back({k, s, e, sc_line, 1'b0});
    endtask

    task automatic bump_line();
        if (sc_line != LineMax) sc_line++;
    endtask

    task automatic scanner_reset();
        sc_mode = M_IDLE; sc_pos = '0; sc_line = 24'd1; sc_start = '0;
        sc_op = '0; sc_prefix = '0; sc_len = '0; sc_err = 1'b0;
    endtask

    task automatic open_token(logic [7:0] c, logic [23:0] p);
        logic [5:0] k;
        k = 6'h3F;
        sc_mode = M_IDLE;
        case (c)
            " ": return;
            8'h0A: begin bump_line(); k = K_NEWLINE; end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            "{": k = K_LCURLY;
            "}": k = K_RCURLY;
            ",": k = K_COMMA;
            ".": k = K_STOP;
            ":": k = K_COLON;
            ";": k = K_SEMI;
            "&": k = K_AMP;
            "@": k = K_AT;
            8'h22: k = K_DQUOTE;
            8'h27: k = K_SQUOTE;
            8'h5C: k = K_BSLASH;
            "=", "<", ">", "/", "+", "-", "*": begin
                sc_mode = M_OP; sc_op = c; sc_start = p; return;
            end
            default: ;
        endcase
        if (k != 6'h3F) begin put_tok(k, p, p + 24'd1); return; end
        sc_start = p;
        if (is_let(c) || c == "_") begin
            sc_mode = M_WORD; sc_prefix = {40'h0, c}; sc_len = 3'd1;
        end else if (c == "0") sc_mode = M_ZERO;
        else if (is_dig(c)) sc_mode = M_DEC;
        else begin put_tok(K_ERROR, p, p + 24'd1); sc_err = 1'b1; end
    endtask

    task automatic op_next(logic [7:0] c, logic [23:0] p);
        logic [5:0] k;
        k = 6'h3F;
        case (sc_op)
            "=": if (c == "=") k = K_EQ;
            "<": if (c == "<") k = K_SHL;
                 else if (c == "=") k = K_LEQ;
                 else if (c == "-") begin sc_mode = M_LT_MINUS; return; end
            ">": if (c == ">") k = K_SHR; else if (c == "=") k = K_GEQ;
            "/": if (c == "*") begin sc_mode = M_BLOCK; return; end
                 else if (c == "/") begin sc_mode = M_LINE; return; end
                 else if (c == "=") k = K_DIV_ASSIGN;
            "+": if (c == "=") k = K_ADD_ASSIGN; else if (c == "+") k = K_INC;
            "-": if (c == "=") k = K_SUB_ASSIGN;
                 else if (c == ">") k = K_ARROW;
                 else if (c == "-") k = K_DEC;
            "*": if (c == "=") k = K_MUL_ASSIGN;
            default: ;
        endcase
        sc_mode = M_IDLE;
        if (k != 6'h3F) put_tok(k, sc_start, p + 24'd1);
        else begin
            put_tok(op_kind(sc_op), sc_start, sc_start + 24'd1);
            open_token(c, p);
        end
    endtask

    // Works out the tokens one byte produces and queues them.
    task automatic predict_tokens(logic [7:0] c, logic fin);
        logic [23:0] p;
        p = sc_pos;
        step_toks.delete();
        if (!sc_err) begin
            case (sc_mode)
                M_OP: op_next(c, p);
                M_LT_MINUS:
                    if (c == ">") begin
                        sc_mode = M_IDLE; put_tok(K_SWAP, sc_start, p + 24'd1);
                    end else begin
                        put_tok(K_LT, sc_start, sc_start + 24'd1);
                        sc_start = sc_start + 24'd1; sc_op = "-";
                        op_next(c, p);
                    end
                M_BLOCK, M_BLOCK_STAR:
                    if (c == "/" && sc_mode == M_BLOCK_STAR) sc_mode = M_IDLE;
                    else if (c == "*") sc_mode = M_BLOCK_STAR;
                    else begin
                        if (c == 8'h0A) bump_line();
                        sc_mode = M_BLOCK;
                    end
                M_LINE: if (c == 8'h0A) open_token(c, p);
                M_WORD:
                    if (is_let(c) || c == "_" || is_dig(c)) begin
                        if (sc_len < 3'd6) sc_prefix = {sc_prefix[39:0], c};
                        if (sc_len < 3'd7) sc_len++;
                    end else begin
                        put_tok(keyword_kind(), sc_start, p); open_token(c, p);
                    end
                M_ZERO:
                    if (c == "b") sc_mode = M_BIN;
                    else if (c == "x" || c == "X") sc_mode = M_HEX;
                    else if (is_dig(c) || c == "_") sc_mode = M_DEC;
                    else begin put_tok(K_DECIMAL, sc_start, p); open_token(c, p); end
                M_BIN:
                    if (!(c == "0" || c == "1" || c == "_")) begin
                        put_tok(K_BIN, sc_start, p); open_token(c, p);
                    end
                M_HEX:
                    if (!(is_hx(c) || c == "_")) begin
                        put_tok(K_HEX, sc_start, p); open_token(c, p);
                    end
                M_DEC:
                    if (!(is_dig(c) || c == "_")) begin
                        put_tok(K_DECIMAL, sc_start, p); open_token(c, p);
                    end
                default: open_token(c, p);
            endcase
        end
        sc_pos = p + 24'd1;
        if (fin) begin
            if (!sc_err) begin
                case (sc_mode)
                    M_OP: put_tok(op_kind(sc_op), sc_start, sc_start + 24'd1);
                    M_LT_MINUS: begin
                        put_tok(K_LT, sc_start, sc_start + 24'd1);
                        put_tok(K_MINUS, sc_start + 24'd1, sc_start + 24'd2);
                    end
                    M_WORD: put_tok(keyword_kind(), sc_start, p + 24'd1);
                    M_ZERO, M_DEC: put_tok(K_DECIMAL, sc_start, p + 24'd1);
                    M_BIN: put_tok(K_BIN, sc_start, p + 24'd1);
                    M_HEX: put_tok(K_HEX, sc_start, p + 24'd1);
                    default: ;
                endcase
            end
            scanner_reset();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    endtask

    // Sends one byte; predicts at acceptance.
    task automatic send_byte(logic [7:0] c, logic fin);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= c;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tokens(c, fin);
        n_bytes++;
    endtask

    task automatic send_text(string s, logic fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && i == s.len() - 1);
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // output stall: bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_tokens++;
            if (tokens_due.size() == 0) begin
                $error("unexpected token kind=%0d", o_token_kind);
                n_errors++;
            end else begin
                want = tokens_due.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    n_errors++;
                end
                if (o_start_pos !== want.start_pos) begin
                    $error("start_pos: expected %0d, got %0d", want.start_pos, o_start_pos);
                    n_errors++;
                end
                if (o_end_pos !== want.end_pos) begin
                    $error("end_pos: expected %0d, got %0d", want.end_pos, o_end_pos);
                    n_errors++;
                end
                if (o_line_num !== want.line_num) begin
                    $error("line_num: expected %0d, got %0d", want.line_num, o_line_num);
                    n_errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("source_text_tokenizer_top_test: done, errors");
            $finish;
        end
    end

    task automatic test_punctuation();
        send_text("()[]{},.:;&@\"'\\ \n", 1'b1);
    endtask

    task automatic test_operators();
        send_text("= == < <= << <-> <-= <- > >= >> / /= + += ++ - -= -> -- * *=", 1'b0);
        send_text("<-", 1'b1);
    endtask

    task automatic test_keywords();
        send_text("fn struct use while for if elif else in structs _x9 fo\n", 1'b0);
        send_text("whilexyz", 1'b1);
    endtask

    task automatic test_literals();
        send_text("0b1_01 0x_fA 0XFF 0 007 19_2 0b2 0xg", 1'b1);
    endtask

    task automatic test_comments();
        send_text("a/* x*\n**/b // c\nd /*/ e*/f/*open", 1'b1);
    endtask

    task automatic test_error_sticky();
        send_text("a$ b c", 1'b1);
        send_byte(8'h09, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("x", 1'b1);
    endtask

    task automatic test_random_text();
        string pieces[24] = '{"fn", "struct", "use", "while", "for", "if", "elif",
            "else", "in", "name_1", "0b10", "0x3F", "42", "0", "<->", "<-", "==",
            "/*c*/", "//z\n", "\n", " ", "(", "->", "*="};
        int n;
        logic [7:0] c;
        while (n_bytes < 240) begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) begin
                if (n_bytes > 225) idle_on = 1'b0;
                if ($urandom_range(0, 19) == 0) begin
                    c = 8'($urandom_range(0, 255));
                    send_byte(c, 1'b0);
                end else send_text(pieces[$urandom_range(0, 23)], 1'b0);
                if ($urandom_range(0, 1)) send_byte(" ", 1'b0);
            end
            c = 8'($urandom_range(32, 126));
            send_byte(c, 1'b1);
        end
        idle_on = 1'b0;
        // every bit of the byte both ways, with final_byte
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    initial begin
        scanner_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_punctuation();
        test_operators();
        test_keywords();
        test_literals();
        test_comments();
        test_error_sticky();
        test_random_text();
        go_quiet();
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes, checked %0d tokens: punctuation, operators,", n_bytes,
                 n_tokens);
        $display("keywords, literals, comments, sticky errors and random text.");
        if (n_errors == 0) begin
            $display("source_text_tokenizer_top_test: done, clean");
        end else begin
            $display("source_text_tokenizer_top_test: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stt_pkg.sv
rtl/source_text_tokenizer_top.sv
verif/source_text_tokenizer_top_test.sv
